// File: hw/rtl/hbc_pkg.sv
// ----------------------------------------------------------------------------
// hbc_pkg: shared types and codes for the hashed block cache tag store
// Command codes, status codes and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package hbc_pkg;

	localparam logic [1:0] CMD_GET     = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_PIN     = 2'd2;
	localparam logic [1:0] CMD_UNPIN   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_REF_ERR = 2'd2;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch request, clear scan results
		logic scan_clr;  // clear scan results only
		logic scan;      // evaluate entry at scan pointer
		logic hashrdy;   // fold one more hash step
		logic grant;     // commit a get (hit or allocate)
		logic touch_one; // commit release/pin/unpin
		logic mru_step;  // one step of the recency shift
		logic mru_fin;   // place target at most recent
	} hbc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hash_done;
		logic is_get;
		logic have_hit;
		logic have_free;
		logic need_mru;
	} hbc_stat_t;

endpackage

// File: hw/rtl/hashed_block_cache_lru_refcount_core.sv
// ----------------------------------------------------------------------------
// hashed_block_cache_lru_refcount_core: buffer cache tag store, LRU + refcounts
// Hashed lookup by (device+block) mod buckets, recency-ranked replacement.
// ----------------------------------------------------------------------------
//  channel | signals                                         | beat
//  in      | in_valid/in_ready, cmd device block_number buffer_index | request
//  out     | out_valid/out_ready, granted_index hit need_fill status | result
//
// A get runs the bucket hash (reciprocal multiply, multiply back and subtract),
// a tag scan over every entry, a commit and a hash check before its result
// is offered; a steal adds the recency shift. Pin, unpin and reference errors
// skip the scan; a release to zero adds a rehash and the shift.
// Reset is asynchronous and fully initializes the store.
// A stalled result holds in the output register; no new beat is taken meanwhile.
module hashed_block_cache_lru_refcount_core import hbc_pkg::*; #(
	parameter int NUM_BUFFERS = 32,
	parameter int NUM_BUCKETS = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] device,
	input  logic [31:0] block_number,
	input  logic [4:0]  buffer_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  granted_index,
	output logic        hit,
	output logic        need_fill,
	output logic [1:0]  status
);
	hbc_cmd_t  ctl;
	hbc_stat_t stat;
	logic [$clog2(NUM_BUFFERS)-1:0] ptr;

	hbc_ctrl #(.NUM_BUFFERS(NUM_BUFFERS)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .ctl, .ptr
	);

	hbc_datapath #(.NUM_BUFFERS(NUM_BUFFERS), .NUM_BUCKETS(NUM_BUCKETS)) u_dp (
		.clk, .arst_n, .ctl, .ptr, .cmd, .device, .block_number, .buffer_index,
		.stat, .res_index(granted_index), .res_hit(hit), .res_fill(need_fill),
		.res_status(status)
	);
endmodule

// File: hw/rtl/hbc_datapath.sv
// ----------------------------------------------------------------------------
// hbc_datapath: tag store, hash folder, scan comparators and recency update
// All state lives here; the controller sequences scans one entry a cycle.
// ----------------------------------------------------------------------------
module hbc_datapath import hbc_pkg::*; #(
	parameter int NUM_BUFFERS = 32,
	parameter int NUM_BUCKETS = 13
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hbc_cmd_t                 ctl,
	input  logic [$clog2(NUM_BUFFERS)-1:0] ptr,
	input  logic [1:0]               cmd,
	input  logic [15:0]              device,
	input  logic [31:0]              block_number,
	input  logic [4:0]               buffer_index,
	output hbc_stat_t                stat,
	output logic [4:0]               res_index,
	output logic                     res_hit,
	output logic                     res_fill,
	output logic [1:0]               res_status
);
	localparam int IW = $clog2(NUM_BUFFERS);
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int LK = $clog2(NUM_BUCKETS);
	// reciprocal of the bucket count, exact floor quotient for any 32-bit sum
	localparam logic [63:0] POW  = 64'd1 << (32 + LK);
	localparam logic [32:0] MREC = 33'((POW + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

	// tag store
	logic [15:0]    tdev_q  [NUM_BUFFERS];
	logic [31:0]    tblk_q  [NUM_BUFFERS];
	logic           valid_q [NUM_BUFFERS];
	logic [7:0]     cnt_q   [NUM_BUFFERS];
	logic [BW-1:0]  home_q  [NUM_BUFFERS];
	logic [IW-1:0]  rank_q  [NUM_BUFFERS];

	// request
	logic [1:0]  cmd_q;
	logic [15:0] dev_q;
	logic [31:0] blk_q;
	logic [4:0]  bi_q;
	logic [IW-1:0] tgt_q;
	// hash: reciprocal multiply, then multiply back and subtract
	logic [31:0]   hsum_q;
	logic [31:0]   quo_q;
	logic [1:0]    hph_q;
	logic [BW-1:0] bk_q;
	// scan results
	logic          hit_q, own_q, oth_q;
	logic [IW-1:0] hsel_q, osel_q, xsel_q;
	logic [BW-1:0] xbk_q;
	logic          need_mru_q;

	logic [71:0] prod_w;
	logic [31:0] rem_w;
	assign prod_w = 72'(hsum_q) * 72'(MREC);
	assign rem_w  = hsum_q - quo_q * 32'(NUM_BUCKETS);

	// rank of the target buffer before the recency shift
	logic [IW-1:0] old_rank;
	assign old_rank = rank_q[tgt_q];

	// status back to the controller
	assign stat.hash_done = (hph_q == 2'd0);
	assign stat.is_get    = (cmd_q == CMD_GET);
	assign stat.have_hit  = hit_q;
	assign stat.have_free = own_q | oth_q;
	assign stat.need_mru  = need_mru_q;

	logic [4:0]  ri_q;
	logic        rh_q, rf_q;
	logic [1:0]  rs_q;
	assign res_index  = ri_q;
	assign res_hit    = rh_q;
	assign res_fill   = rf_q;
	assign res_status = rs_q;

	logic [BW-1:0] eb;
	logic          emt, efr;
	always_comb begin
		eb  = home_q[ptr];
		emt = (eb == bk_q) && (tdev_q[ptr] == dev_q) && (tblk_q[ptr] == blk_q);
		efr = (cnt_q[ptr] == 8'd0);
	end

	logic [IW-1:0] sel;
	always_comb begin
		sel = hit_q ? hsel_q : (own_q ? osel_q : xsel_q);
	end

	// all state registers: tag store, request, hash, scan results and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				tdev_q[i]  <= '0;
				tblk_q[i]  <= '0;
				valid_q[i] <= 1'b0;
				cnt_q[i]   <= '0;
				home_q[i]  <= BW'(i % NUM_BUCKETS);
				rank_q[i]  <= IW'(i);
			end
			hit_q <= 1'b0; own_q <= 1'b0; oth_q <= 1'b0;
			need_mru_q <= 1'b0;
			hph_q  <= '0;
			hsum_q <= '0;
			quo_q  <= '0;
		end else begin
			if (ctl.load) begin
				cmd_q <= cmd; dev_q <= device; blk_q <= block_number; bi_q <= buffer_index;
				tgt_q <= IW'(buffer_index);
				hsum_q <= {16'd0, device} + block_number;
				hph_q <= 2'd2;
				need_mru_q <= 1'b0;
			end
			if (ctl.load || ctl.scan_clr) begin
				hit_q <= 1'b0; own_q <= 1'b0; oth_q <= 1'b0;
			end
			if (ctl.hashrdy) begin
				if (hph_q == 2'd2) begin
					quo_q <= prod_w[32+LK +: 32];
					hph_q <= 2'd1;
				end else if (hph_q == 2'd1) begin
					bk_q  <= rem_w[BW-1:0];
					hph_q <= 2'd0;
				end
			end
			// scan one entry
			if (ctl.scan) begin
				if (emt && (!hit_q || rank_q[ptr] > rank_q[hsel_q])) begin
					hit_q <= 1'b1; hsel_q <= ptr;
				end
				if (efr && eb == bk_q && (!own_q || rank_q[ptr] < rank_q[osel_q])) begin
					own_q <= 1'b1; osel_q <= ptr;
				end
				// other buckets: lowest bucket first, then least recent
				if (efr && eb != bk_q && (!oth_q || eb < xbk_q ||
						(eb == xbk_q && rank_q[ptr] < rank_q[xsel_q]))) begin
					oth_q <= 1'b1; xsel_q <= ptr; xbk_q <= eb;
				end
			end
			if (ctl.grant) begin
				if (hit_q || own_q || oth_q) begin
					ri_q <= 5'(sel); rh_q <= hit_q;
					rf_q <= (hit_q && valid_q[sel]) ? 1'b0 : 1'b1;
					rs_q <= ST_OK;
					valid_q[sel] <= 1'b1;
					if (hit_q) begin
						if (cnt_q[sel] != COUNT_MAX) cnt_q[sel] <= cnt_q[sel] + 8'd1;
					end else begin
						tdev_q[sel] <= dev_q; tblk_q[sel] <= blk_q; cnt_q[sel] <= 8'd1;
						if (!own_q) begin
							home_q[sel] <= bk_q; tgt_q <= sel; need_mru_q <= 1'b1;
						end
					end
				end else begin
					ri_q <= '0; rh_q <= 1'b0; rf_q <= 1'b0; rs_q <= ST_NO_FREE;
				end
			end
			if (ctl.touch_one) begin
				ri_q <= '0; rh_q <= 1'b0; rf_q <= 1'b0;
				if (32'(bi_q) >= NUM_BUFFERS) rs_q <= ST_REF_ERR;
				else if (cmd_q == CMD_PIN) begin
					rs_q <= ST_OK;
					if (cnt_q[tgt_q] != COUNT_MAX) cnt_q[tgt_q] <= cnt_q[tgt_q] + 8'd1;
				end else if (cnt_q[tgt_q] == 8'd0) rs_q <= ST_REF_ERR;
				else begin
					rs_q <= ST_OK;
					cnt_q[tgt_q] <= cnt_q[tgt_q] - 8'd1;
					if (cmd_q == CMD_RELEASE && cnt_q[tgt_q] == 8'd1) begin
						need_mru_q <= 1'b1;
						dev_q <= tdev_q[tgt_q]; blk_q <= tblk_q[tgt_q];
						hsum_q <= {16'd0, tdev_q[tgt_q]} + tblk_q[tgt_q];
						hph_q <= 2'd2;
					end
				end
			end
			if (ctl.mru_step && rank_q[ptr] > old_rank) rank_q[ptr] <= rank_q[ptr] - IW'(1);
			if (ctl.mru_fin) begin
				rank_q[tgt_q] <= IW'(NUM_BUFFERS - 1);
				if (cmd_q == CMD_RELEASE) home_q[tgt_q] <= bk_q;
				need_mru_q <= 1'b0;
			end
		end
	end
endmodule

// File: hw/rtl/hbc_ctrl.sv
// ----------------------------------------------------------------------------
// hbc_ctrl: sequencer for hash, tag scan, commit and recency update
// One request at a time; result held in an output register until taken.
// ----------------------------------------------------------------------------
module hbc_ctrl import hbc_pkg::*; #(
	parameter int NUM_BUFFERS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  hbc_stat_t stat,
	output hbc_cmd_t  ctl,
	output logic [$clog2(NUM_BUFFERS)-1:0] ptr
);
	localparam int IW = $clog2(NUM_BUFFERS);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_HASH = 8'b00000010,
		S_SCAN = 8'b00000100,
		S_COMM = 8'b00001000,
		S_RHSH = 8'b00010000,
		S_MRU  = 8'b00100000,
		S_MFIN = 8'b01000000,
		S_OUT  = 8'b10000000
	} state_t;

	state_t state_q;
	logic [IW-1:0] ptr_q;
	logic last;
	assign ptr  = ptr_q;
	assign last = (ptr_q == IW'(NUM_BUFFERS - 1));
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		ctl = '0;
		case (state_q)
			S_IDLE: ctl.load = in_valid;
			S_HASH: ctl.hashrdy = 1'b1;
			S_SCAN: ctl.scan = 1'b1;
			S_COMM: begin
				ctl.grant = stat.is_get;
				ctl.touch_one = !stat.is_get;
			end
			S_RHSH: ctl.hashrdy = 1'b1;
			S_MRU:  ctl.mru_step = 1'b1;
			S_MFIN: ctl.mru_fin = 1'b1;
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_HASH;
				S_HASH: if (stat.hash_done) begin
					ptr_q   <= '0;
					state_q <= stat.is_get ? S_SCAN : S_COMM;
				end
				S_SCAN: begin
					ptr_q <= ptr_q + IW'(1);
					if (last) state_q <= S_COMM;
				end
				S_COMM: state_q <= S_RHSH;
				S_RHSH: if (stat.hash_done) begin
					ptr_q   <= '0;
					state_q <= stat.need_mru ? S_MRU : S_OUT;
				end
				S_MRU: begin
					ptr_q <= ptr_q + IW'(1);
					if (last) state_q <= S_MFIN;
				end
				S_MFIN: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/hbc_checker.sv
// ----------------------------------------------------------------------------
// hbc_checker: port-level checks for the buffer cache core
// Handshake stability and result encoding rules.
// ----------------------------------------------------------------------------
module hbc_checker import hbc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] granted_index,
	input logic       hit,
	input logic       need_fill,
	input logic [1:0] status
);
	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_index))
		else $error("result changed while stalled");
	// no new request while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input ready with result pending");
	// failed results carry no grant
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> !hit && !need_fill && granted_index == 5'd0)
		else $error("error result carries grant");
	// status stays in range
	a_status_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status code");
endmodule

bind hashed_block_cache_lru_refcount_core hbc_checker u_hbc_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.granted_index, .hit, .need_fill, .status
);

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: hashed block cache tag store
// Drives get/release/pin/unpin beats with random gaps and output stalls,
// predicts each result from an internal copy of the tag store and checks
// every result beat field by field in order.
// ----------------------------------------------------------------------------
module testbench import hbc_pkg::*;;

	localparam int NBUF = 32;
	localparam int NBKT = 13;

	typedef struct packed {
		logic [4:0] idx;
		logic       hit;
		logic       fill;
		logic [1:0] st;
	} cache_reply_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [15:0] device;
	logic [31:0] block_number;
	logic [4:0]  buffer_index;
	logic        out_valid;
	logic        out_ready;
	logic [4:0]  granted_index;
	logic        hit;
	logic        need_fill;
	logic [1:0]  status;

	// predicted store
	logic [15:0] tag_dev [NBUF];
	logic [31:0] tag_blk [NBUF];
	logic        loaded  [NBUF];
	logic [7:0]  refcnt  [NBUF];
	int          home    [NBUF];
	int          rank    [NBUF];

	cache_reply_t replies_due[$];
	int           held_bufs[$];
	int           errors = 0;
	bit           drain_quiet = 1'b0;

	hashed_block_cache_lru_refcount_core #(
		.NUM_BUFFERS(NBUF),
		.NUM_BUCKETS(NBKT)
	) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .device(device), .block_number(block_number),
		.buffer_index(buffer_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.granted_index(granted_index), .hit(hit), .need_fill(need_fill),
		.status(status)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// --- predictor ---------------------------------------------------------
	function automatic int bucket_of(logic [15:0] d, logic [31:0] b);
		logic [31:0] sum;
		sum = {16'd0, d} + b;
		return int'(sum % NBKT);
	endfunction

	function automatic void promote(int k);
		int prior;
		prior = rank[k];
		for (int i = 0; i < NBUF; i++)
			if (rank[i] > prior)
				rank[i]--;
		rank[k] = NBUF - 1;
	endfunction

	function automatic int oldest_free(int bk);
		int best;
		best = -1;
		for (int i = 0; i < NBUF; i++)
			if (home[i] == bk && refcnt[i] == 0 && (best < 0 || rank[i] < rank[best]))
				best = i;
		return best;
	endfunction

	function automatic void store_reset();
		for (int i = 0; i < NBUF; i++) begin
			tag_dev[i] = '0;
			tag_blk[i] = '0;
			loaded[i]  = 1'b0;
			refcnt[i]  = '0;
			home[i]    = i % NBKT;
			rank[i]    = i;
		end
	endfunction

	function automatic cache_reply_t cache_apply(logic [1:0] c, logic [15:0] d,
			logic [31:0] b, logic [4:0] bi);
		cache_reply_t r;
		int bk, sel;
		bit stolen;
		r = '0;
		r.st = ST_OK;
		if (c == CMD_GET) begin
			bk = bucket_of(d, b);
			sel = -1;
			stolen = 1'b0;
			// most recent tag match in the bucket, valid or not
			for (int i = 0; i < NBUF; i++)
				if (home[i] == bk && tag_dev[i] == d && tag_blk[i] == b &&
						(sel < 0 || rank[i] > rank[sel]))
					sel = i;
			if (sel >= 0) begin
				r.hit = 1'b1;
				if (refcnt[sel] != COUNT_MAX)
					refcnt[sel]++;
			end else begin
				sel = oldest_free(bk);
				for (int k = 0; sel < 0 && k < NBKT; k++) begin
					if (k == bk)
						continue;
					sel = oldest_free(k);
					if (sel >= 0)
						stolen = 1'b1;
				end
				if (sel >= 0) begin
					tag_dev[sel] = d;
					tag_blk[sel] = b;
					loaded[sel]  = 1'b0;
					refcnt[sel]  = 8'd1;
					if (stolen) begin
						home[sel] = bk;
						promote(sel);
					end
				end
			end
			if (sel >= 0) begin
				r.idx  = sel[4:0];
				r.fill = !loaded[sel];
				loaded[sel] = 1'b1;
			end else begin
				r.st = ST_NO_FREE;
			end
		end else if (c == CMD_PIN) begin
			if (refcnt[bi] != COUNT_MAX)
				refcnt[bi]++;
		end else if (refcnt[bi] == 0) begin
			r.st = ST_REF_ERR;
		end else begin
			refcnt[bi]--;
			if (c == CMD_RELEASE && refcnt[bi] == 0) begin
				home[bi] = bucket_of(tag_dev[bi], tag_blk[bi]);
				promote(bi);
			end
		end
		return r;
	endfunction

	// --- driving -----------------------------------------------------------
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one request beat; called and returns at a falling edge
	task automatic send_beat(input logic [1:0] c, input logic [15:0] d,
			input logic [31:0] b, input logic [4:0] bi);
		cache_reply_t r;
		int n;
		in_valid     = 1'b1;
		cmd          = c;
		device       = d;
		block_number = b;
		buffer_index = bi;
		do
			@(posedge clk);
		while (!in_ready);
		r = cache_apply(c, d, b, bi);
		replies_due.push_back(r);
		if (c == CMD_GET && r.st == ST_OK)
			held_bufs.push_back(int'(r.idx));
		@(negedge clk);
		n = gap_len();
		if (n > 0) begin
			in_valid = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic release_held();
		while (held_bufs.size() > 0)
			send_beat(CMD_RELEASE, '0, '0, 5'(held_bufs.pop_front()));
	endtask

	// result side stalls; quiet stretches keep some runs stall free
	initial begin
		int hold;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (drain_quiet || $urandom_range(0, 3) == 0) begin
				out_ready = 1'b1;
				repeat ($urandom_range(1, 60)) @(negedge clk);
			end else begin
				hold = gap_len();
				out_ready = (hold == 0);
				repeat (hold) @(negedge clk);
				out_ready = 1'b1;
			end
		end
	end

	// --- checking ----------------------------------------------------------
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		cache_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				report_mismatch("result count", 1, 0);
			end else begin
				want = replies_due.pop_front();
				if (granted_index !== want.idx)
					report_mismatch("granted_index", int'(granted_index), int'(want.idx));
				if (hit !== want.hit)
					report_mismatch("hit", int'(hit), int'(want.hit));
				if (need_fill !== want.fill)
					report_mismatch("need_fill", int'(need_fill), int'(want.fill));
				if (status !== want.st)
					report_mismatch("status", int'(status), int'(want.st));
			end
		end
	end

	// --- tests -------------------------------------------------------------
	// reset tags are zero, so block 0 on device 0 hits before any fill
	task automatic test_reset_tags();
		send_beat(CMD_GET, 16'd0, 32'd0, '0);
		send_beat(CMD_GET, 16'd0, 32'd0, '0);
		release_held();
		send_beat(CMD_RELEASE, '0, '0, 5'd26);
		send_beat(CMD_UNPIN, '0, '0, 5'd31);
		send_beat(CMD_PIN, '0, '0, 5'd0);
		send_beat(CMD_UNPIN, '0, '0, 5'd0);
	endtask

	// miss recycles in the bucket, then steals once the bucket is busy
	task automatic test_recycle_steal();
		for (int k = 0; k < 5; k++)
			send_beat(CMD_GET, 16'd1, 32'd12 + 32'd13 * k, '0);
		send_beat(CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, '0);
		send_beat(CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, '0);
		release_held();
		send_beat(CMD_GET, 16'd1, 32'd25, '0);
		release_held();
	endtask

	// every buffer held: a further get finds nothing free
	task automatic test_exhaust();
		for (int k = 0; k < NBUF; k++)
			send_beat(CMD_GET, 16'd7, 32'd1000 + k, '0);
		send_beat(CMD_GET, 16'd8, 32'd5, '0);
		release_held();
	endtask

	// count saturation via pin and via a hit
	task automatic test_saturation();
		int g;
		send_beat(CMD_GET, 16'd3, 32'd4, '0);
		g = held_bufs.pop_back();
		repeat (255) send_beat(CMD_PIN, '0, '0, g[4:0]);
		send_beat(CMD_GET, 16'd3, 32'd4, '0);
		void'(held_bufs.pop_back());
	endtask

	// mostly well-formed traffic on a small block pool, some raw noise
	task automatic test_random(input int count);
		int p;
		for (int n = 0; n < count; n++) begin
			p = $urandom_range(0, 99);
			if (p < 45 && held_bufs.size() < 20)
				send_beat(CMD_GET, 16'($urandom_range(0, 3)),
					32'($urandom_range(0, 40)), 5'($urandom));
			else if (p < 75 && held_bufs.size() > 0)
				send_beat(CMD_RELEASE, 16'($urandom), $urandom,
					5'(held_bufs.pop_front()));
			else if (p < 85)
				send_beat(2'($urandom_range(CMD_PIN, CMD_UNPIN)), 16'($urandom),
					$urandom, 5'($urandom));
			else
				send_beat(2'($urandom), 16'($urandom), $urandom, 5'($urandom));
			if (n % 100 == 50)
				drain_quiet = !drain_quiet;
		end
	endtask

	// --- main sequence -----------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = CMD_GET;
		device       = '0;
		block_number = '0;
		buffer_index = '0;
		store_reset();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_tags();
		test_recycle_steal();
		test_exhaust();
		test_saturation();
		test_random(100);
		in_valid = 1'b0;
		wait (replies_due.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
